// ===== design/tfdt_pkg.sv =====
// ----------------------------------------------------------------------------
// tfdt_pkg
// Shared constants, request codes and controller/datapath handshake types
// for the tiled frame buffer dirty tracker.
// ----------------------------------------------------------------------------
package tfdt_pkg;

    // default build limits
    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT_DEF = 256;
    localparam int COLOR_BITS_DEF = 24;

    // field widths
    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 2;
    localparam int REQ_W     = 2;
    localparam int POS_W     = 8;
    localparam int PIX_W     = 24;
    localparam int TIDX_W    = 16;
    localparam int DIV_W     = 10;
    localparam int COUNT_W   = 18;
    localparam int TILE_MAX  = 256;

    // request codes
    localparam logic [REQ_W-1:0] REQ_WRITE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_QUERY = 2'd2;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TILE_WIDTH   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TILE_HEIGHT  = 2'd3;

    // register reset values
    localparam logic [CFG_W-1:0] FRAME_SIZE_RST = 9'd256;
    localparam logic [CFG_W-1:0] TILE_SIZE_RST  = 9'd8;

    typedef struct packed {
        logic init_clear;
        logic cfg_we;
        logic cfg_div_start;
        logic cfg_mul;
        logic latch_in;
        logic calc;
        logic pix_wr;
        logic pix_rd;
        logic tile_div_start;
        logic tile_mul;
        logic dirty_set;
        logic dirty_rd;
        logic dirty_clr;
        logic load_out;
    } tfdt_cmd_t;

    typedef struct packed {
        logic             init_last;
        logic             div_busy;
        logic [REQ_W-1:0] req_type;
        logic             err;
    } tfdt_stat_t;

    // zero reads as one, anything above the limit reads as the limit
    function automatic logic [CFG_W-1:0] clamp_reg(input logic [CFG_W-1:0] v, input int hi);
        logic [CFG_W-1:0] r;
        if (v == '0)
        begin
            r = 9'd1;
        end
        else if (32'(v) > hi)
        begin
            r = CFG_W'(hi);
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ===== design/tfdt_ifs.sv =====
// ----------------------------------------------------------------------------
// tfdt channel interfaces
// Request, response and configuration channels, each with valid and ready.
// ----------------------------------------------------------------------------
interface tfdt_req_if;
    logic                          valid;
    logic                          ready;
    logic [tfdt_pkg::REQ_W-1:0]    req_type;
    logic [tfdt_pkg::POS_W-1:0]    pos_x;
    logic [tfdt_pkg::POS_W-1:0]    pos_y;
    logic [tfdt_pkg::PIX_W-1:0]    pixel_value;
    logic [tfdt_pkg::TIDX_W-1:0]   tile_index;

    modport source (output valid, req_type, pos_x, pos_y, pixel_value, tile_index,
                    input ready);
    modport sink (input valid, req_type, pos_x, pos_y, pixel_value, tile_index,
                  output ready);
endinterface

interface tfdt_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [tfdt_pkg::PIX_W-1:0]  read_value;
    logic                        tile_dirty;
    logic                        status;

    modport source (output valid, read_value, tile_dirty, status, input ready);
    modport sink (input valid, read_value, tile_dirty, status, output ready);
endinterface

interface tfdt_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [tfdt_pkg::CFG_IDX_W-1:0]   index;
    logic [tfdt_pkg::CFG_W-1:0]       data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== design/tiled_framebuffer_dirty_tracker.sv =====
// ----------------------------------------------------------------------------
// tiled_framebuffer_dirty_tracker
// Pixel store with one dirty flag per rectangular tile.
// ----------------------------------------------------------------------------
// Usage:
//   req  - one transaction per request: write pixel, read pixel, query tile
//          or clear tile. Every request gives exactly one transaction on rsp.
//   rsp  - read_value, tile_dirty and status (1 for an out of range position
//          or tile index, in which case nothing is changed).
//   cfg  - register writes (frame width/height, tile width/height), taken only
//          while no request is in flight; each write is followed by a
//          recompute of the tile grid before the next request.
// Sequence: a read, query, clear or rejected request is latched, range checked
//   and addressed, executed, then loaded into the result register; a pixel
//   write is stored, then waits for the two bit-serial tile dividers, forms
//   the tile index and sets its flag. One request is worked on at a time.
// Reset: all MAX_WIDTH * MAX_HEIGHT dirty flags (65536 by default) are filled
//   with ones, one flag per cycle, followed by the grid recompute; req and cfg
//   are held not ready until then.
// Stall: the result waits in the output register; the next request is still
//   accepted and runs up to its own result, which waits until rsp is free.
// ----------------------------------------------------------------------------
module tiled_framebuffer_dirty_tracker
#(
    parameter int MAX_WIDTH  = tfdt_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = tfdt_pkg::MAX_HEIGHT_DEF,
    parameter int COLOR_BITS = tfdt_pkg::COLOR_BITS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    tfdt_req_if.sink   req,
    tfdt_rsp_if.source rsp,
    tfdt_cfg_if.sink   cfg
);

    tfdt_pkg::tfdt_cmd_t  cmd;
    tfdt_pkg::tfdt_stat_t stat;

    tfdt_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .cfg_valid (cfg.valid),
        .cfg_ready (cfg.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    tfdt_datapath
    #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .COLOR_BITS (COLOR_BITS)
    )
    u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .cfg_index   (cfg.index),
        .cfg_data    (cfg.data),
        .req_type    (req.req_type),
        .pos_x       (req.pos_x),
        .pos_y       (req.pos_y),
        .pixel_value (req.pixel_value),
        .tile_index  (req.tile_index),
        .read_value  (rsp.read_value),
        .tile_dirty  (rsp.tile_dirty),
        .status      (rsp.status)
    );

endmodule

// ===== design/tfdt_divider.sv =====
// ----------------------------------------------------------------------------
// tfdt_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tfdt_divider
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [tfdt_pkg::DIV_W-1:0]   dividend,
    input  logic [tfdt_pkg::CFG_W-1:0]   divisor,
    output logic                         busy,
    output logic [tfdt_pkg::DIV_W-1:0]   quotient
);

    localparam int CNT_W = $clog2(tfdt_pkg::DIV_W);

    logic                         busy_reg, busy_next;
    logic [CNT_W-1:0]             cnt_reg, cnt_next;
    logic [tfdt_pkg::CFG_W-1:0]   rem_reg, rem_next;
    logic [tfdt_pkg::DIV_W-1:0]   quo_reg, quo_next;
    logic [tfdt_pkg::CFG_W-1:0]   dsr_reg, dsr_next;
    logic [tfdt_pkg::DIV_W-1:0]   trial;
    logic [tfdt_pkg::DIV_W-1:0]   diff;
    logic                         ge;

    always_comb
    begin
        trial = {rem_reg, quo_reg[tfdt_pkg::DIV_W-1]};
        diff  = trial - {1'b0, dsr_reg};
        ge    = trial >= {1'b0, dsr_reg};

        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            // remainder stays below the divisor, so it fits the narrower register
            rem_next  = ge ? diff[tfdt_pkg::CFG_W-1:0] : trial[tfdt_pkg::CFG_W-1:0];
            quo_next  = {quo_reg[tfdt_pkg::DIV_W-2:0], ge};
            cnt_next  = cnt_reg + 1'b1;
            busy_next = cnt_reg != CNT_W'(tfdt_pkg::DIV_W - 1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

// ===== design/tfdt_datapath.sv =====
// ----------------------------------------------------------------------------
// tfdt_datapath
// Configuration registers, pixel store, dirty flag store, address and tile
// arithmetic, and the result register.
// ----------------------------------------------------------------------------
module tfdt_datapath
#(
    parameter int MAX_WIDTH  = tfdt_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = tfdt_pkg::MAX_HEIGHT_DEF,
    parameter int COLOR_BITS = tfdt_pkg::COLOR_BITS_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  tfdt_pkg::tfdt_cmd_t              cmd,
    output tfdt_pkg::tfdt_stat_t             stat,
    input  logic [tfdt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tfdt_pkg::CFG_W-1:0]       cfg_data,
    input  logic [tfdt_pkg::REQ_W-1:0]       req_type,
    input  logic [tfdt_pkg::POS_W-1:0]       pos_x,
    input  logic [tfdt_pkg::POS_W-1:0]       pos_y,
    input  logic [tfdt_pkg::PIX_W-1:0]       pixel_value,
    input  logic [tfdt_pkg::TIDX_W-1:0]      tile_index,
    output logic [tfdt_pkg::PIX_W-1:0]       read_value,
    output logic                             tile_dirty,
    output logic                             status
);

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);

    logic [tfdt_pkg::CFG_W-1:0]     fw_reg, fh_reg, tw_reg, th_reg;
    logic [tfdt_pkg::CFG_W-1:0]     cols_reg;
    logic [tfdt_pkg::COUNT_W-1:0]   count_reg;
    logic [ADDR_W-1:0]              clr_cnt_reg;

    logic [tfdt_pkg::REQ_W-1:0]     req_reg;
    logic [tfdt_pkg::POS_W-1:0]     x_reg, y_reg;
    logic [COLOR_BITS-1:0]          pix_reg;
    logic [tfdt_pkg::TIDX_W-1:0]    tidx_reg;
    logic [ADDR_W-1:0]              addr_reg;
    logic                           err_reg;
    logic [ADDR_W-1:0]              tile_reg;
    logic [COLOR_BITS-1:0]          rd_pix_reg;
    logic                           rd_dirty_reg;
    logic [tfdt_pkg::PIX_W-1:0]     read_value_reg;
    logic                           tile_dirty_reg;
    logic                           status_reg;

    logic [COLOR_BITS-1:0]          pixel_mem [DEPTH];
    logic                           dirty_mem [DEPTH];

    logic                           div_start;
    logic [tfdt_pkg::DIV_W-1:0]     dvd_a, dvd_b, quo_a, quo_b;
    logic                           busy_a, busy_b;
    logic [tfdt_pkg::COUNT_W-1:0]   pix_addr, tile_sum, count_prod;
    logic                           is_pixel, pix_err, tile_err;
    logic                           dirty_we, dirty_wdata;
    logic [ADDR_W-1:0]              dirty_waddr;

    // ceil sizes after a register change, tile coordinates on a pixel write
    assign div_start = cmd.cfg_div_start | cmd.tile_div_start;
    assign dvd_a = cmd.cfg_div_start ? ({1'b0, fw_reg} + {1'b0, tw_reg} - 10'd1)
                                     : tfdt_pkg::DIV_W'(x_reg);
    assign dvd_b = cmd.cfg_div_start ? ({1'b0, fh_reg} + {1'b0, th_reg} - 10'd1)
                                     : tfdt_pkg::DIV_W'(y_reg);

    tfdt_divider u_div_x
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dvd_a),
        .divisor  (tw_reg),
        .busy     (busy_a),
        .quotient (quo_a)
    );

    tfdt_divider u_div_y
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dvd_b),
        .divisor  (th_reg),
        .busy     (busy_b),
        .quotient (quo_b)
    );

    always_comb
    begin
        is_pixel   = (req_reg == tfdt_pkg::REQ_WRITE) || (req_reg == tfdt_pkg::REQ_READ);
        pix_err    = ({1'b0, x_reg} >= fw_reg) || ({1'b0, y_reg} >= fh_reg);
        tile_err   = tfdt_pkg::COUNT_W'(tidx_reg) >= count_reg;
        pix_addr   = tfdt_pkg::COUNT_W'(x_reg)
                   + tfdt_pkg::COUNT_W'(y_reg) * tfdt_pkg::COUNT_W'(fw_reg);
        tile_sum   = tfdt_pkg::COUNT_W'(quo_a[tfdt_pkg::POS_W-1:0])
                   + tfdt_pkg::COUNT_W'(quo_b[tfdt_pkg::POS_W-1:0])
                   * tfdt_pkg::COUNT_W'(cols_reg);
        count_prod = tfdt_pkg::COUNT_W'(quo_a[tfdt_pkg::CFG_W-1:0])
                   * tfdt_pkg::COUNT_W'(quo_b[tfdt_pkg::CFG_W-1:0]);

        dirty_we    = cmd.init_clear | cmd.dirty_set | cmd.dirty_clr;
        dirty_wdata = !cmd.dirty_clr;
        if (cmd.init_clear)
        begin
            dirty_waddr = clr_cnt_reg;
        end
        else if (cmd.dirty_set)
        begin
            dirty_waddr = tile_reg;
        end
        else
        begin
            dirty_waddr = addr_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg      <= tfdt_pkg::clamp_reg(tfdt_pkg::FRAME_SIZE_RST, MAX_WIDTH);
            fh_reg      <= tfdt_pkg::clamp_reg(tfdt_pkg::FRAME_SIZE_RST, MAX_HEIGHT);
            tw_reg      <= tfdt_pkg::TILE_SIZE_RST;
            th_reg      <= tfdt_pkg::TILE_SIZE_RST;
            clr_cnt_reg <= '0;
        end
        else
        begin
            if (cmd.cfg_we)
            begin
                case (cfg_index)
                    tfdt_pkg::REG_FRAME_WIDTH:
                        fw_reg <= tfdt_pkg::clamp_reg(cfg_data, MAX_WIDTH);
                    tfdt_pkg::REG_FRAME_HEIGHT:
                        fh_reg <= tfdt_pkg::clamp_reg(cfg_data, MAX_HEIGHT);
                    tfdt_pkg::REG_TILE_WIDTH:
                        tw_reg <= tfdt_pkg::clamp_reg(cfg_data, tfdt_pkg::TILE_MAX);
                    tfdt_pkg::REG_TILE_HEIGHT:
                        th_reg <= tfdt_pkg::clamp_reg(cfg_data, tfdt_pkg::TILE_MAX);
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.init_clear)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cfg_mul)
        begin
            cols_reg  <= quo_a[tfdt_pkg::CFG_W-1:0];
            count_reg <= count_prod;
        end
        if (cmd.latch_in)
        begin
            req_reg  <= req_type;
            x_reg    <= pos_x;
            y_reg    <= pos_y;
            pix_reg  <= COLOR_BITS'(pixel_value);
            tidx_reg <= tile_index;
        end
        if (cmd.calc)
        begin
            // an address is only used when the range check passed, so it fits
            addr_reg <= is_pixel ? ADDR_W'(pix_addr) : ADDR_W'(tidx_reg);
            err_reg  <= is_pixel ? pix_err : tile_err;
        end
        if (cmd.tile_mul)
        begin
            tile_reg <= ADDR_W'(tile_sum);
        end
        if (cmd.load_out)
        begin
            read_value_reg <= (!err_reg && req_reg == tfdt_pkg::REQ_READ)
                              ? tfdt_pkg::PIX_W'(rd_pix_reg) : '0;
            tile_dirty_reg <= !err_reg && req_reg == tfdt_pkg::REQ_QUERY && rd_dirty_reg;
            status_reg     <= err_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pix_wr)
        begin
            pixel_mem[addr_reg] <= pix_reg;
        end
        if (cmd.pix_rd)
        begin
            rd_pix_reg <= pixel_mem[addr_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (dirty_we)
        begin
            dirty_mem[dirty_waddr] <= dirty_wdata;
        end
        if (cmd.dirty_rd)
        begin
            rd_dirty_reg <= dirty_mem[addr_reg];
        end
    end

    assign stat.init_last = clr_cnt_reg == ADDR_W'(DEPTH - 1);
    assign stat.div_busy  = busy_a | busy_b;
    assign stat.req_type  = req_reg;
    assign stat.err       = err_reg;

    assign read_value = read_value_reg;
    assign tile_dirty = tile_dirty_reg;
    assign status     = status_reg;

endmodule

// ===== design/tfdt_ctrl.sv =====
// ----------------------------------------------------------------------------
// tfdt_ctrl
// Sequencer: flag store fill after reset, size recompute after a register
// write, request execution and result handshake.
// ----------------------------------------------------------------------------
module tfdt_ctrl
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    output logic                     out_valid,
    input  logic                     out_ready,
    input  tfdt_pkg::tfdt_stat_t     stat,
    output tfdt_pkg::tfdt_cmd_t      cmd
);

    localparam logic [3:0] S_INIT      = 4'd0;
    localparam logic [3:0] S_CFG_DIV   = 4'd1;
    localparam logic [3:0] S_CFG_WAIT  = 4'd2;
    localparam logic [3:0] S_CFG_MUL   = 4'd3;
    localparam logic [3:0] S_IDLE      = 4'd4;
    localparam logic [3:0] S_CALC      = 4'd5;
    localparam logic [3:0] S_EXEC      = 4'd6;
    localparam logic [3:0] S_TILE_WAIT = 4'd7;
    localparam logic [3:0] S_TILE_MUL  = 4'd8;
    localparam logic [3:0] S_DIRTY_SET = 4'd9;
    localparam logic [3:0] S_RESP      = 4'd10;

    logic [3:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_ready   = 1'b0;
        cfg_ready  = 1'b0;

        case (state_reg)
            S_INIT:
            begin
                cmd.init_clear = 1'b1;
                if (stat.init_last)
                begin
                    state_next = S_CFG_DIV;
                end
            end
            S_CFG_DIV:
            begin
                cmd.cfg_div_start = 1'b1;
                state_next        = S_CFG_WAIT;
            end
            S_CFG_WAIT:
            begin
                if (!stat.div_busy)
                begin
                    state_next = S_CFG_MUL;
                end
            end
            S_CFG_MUL:
            begin
                cmd.cfg_mul = 1'b1;
                state_next  = S_IDLE;
            end
            S_IDLE:
            begin
                cfg_ready = 1'b1;
                in_ready  = !cfg_valid;
                if (cfg_valid)
                begin
                    cmd.cfg_we = 1'b1;
                    state_next = S_CFG_DIV;
                end
                else if (in_valid)
                begin
                    cmd.latch_in = 1'b1;
                    state_next   = S_CALC;
                end
            end
            S_CALC:
            begin
                cmd.calc   = 1'b1;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = S_RESP;
                if (!stat.err)
                begin
                    case (stat.req_type)
                        tfdt_pkg::REQ_WRITE:
                        begin
                            cmd.pix_wr         = 1'b1;
                            cmd.tile_div_start = 1'b1;
                            state_next         = S_TILE_WAIT;
                        end
                        tfdt_pkg::REQ_READ:
                        begin
                            cmd.pix_rd = 1'b1;
                        end
                        tfdt_pkg::REQ_QUERY:
                        begin
                            cmd.dirty_rd = 1'b1;
                        end
                        default:
                        begin
                            cmd.dirty_clr = 1'b1;
                        end
                    endcase
                end
            end
            S_TILE_WAIT:
            begin
                if (!stat.div_busy)
                begin
                    state_next = S_TILE_MUL;
                end
            end
            S_TILE_MUL:
            begin
                cmd.tile_mul = 1'b1;
                state_next   = S_DIRTY_SET;
            end
            S_DIRTY_SET:
            begin
                cmd.dirty_set = 1'b1;
                state_next    = S_RESP;
            end
            S_RESP:
            begin
                // wait here only while the previous result is still held
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the tiled frame buffer dirty tracker against a cycle-free predictor
// of its pixel store and tile flags, over several frame and tile geometries,
// with random gaps on the request side and random stalls on the response side.
// ----------------------------------------------------------------------------
module tb_top;
    import tfdt_pkg::*;

    localparam int STORE_DEPTH     = MAX_WIDTH_DEF * MAX_HEIGHT_DEF;
    localparam int LIMIT_CYCLES    = 2000000;
    localparam int RSP_HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES     = 40;

    localparam logic ST_OK    = 1'b0;
    localparam logic ST_RANGE = 1'b1;

    typedef struct {
        logic [REQ_W-1:0]  kind;
        logic [POS_W-1:0]  x;
        logic [POS_W-1:0]  y;
        logic [PIX_W-1:0]  color;
        logic [TIDX_W-1:0] tile;
    } pixel_req_t;

    typedef struct {
        logic [PIX_W-1:0] read_value;
        logic             tile_dirty;
        logic             status;
    } pixel_rsp_t;

    class framebuffer_scoreboard;
        int               frame_w;
        int               frame_h;
        int               tile_w;
        int               tile_h;
        logic [PIX_W-1:0] pixels [STORE_DEPTH];
        bit               pixel_written [STORE_DEPTH];
        int               written_addrs [$];
        bit               dirty [STORE_DEPTH];
        pixel_rsp_t       expected_q [$];
        int               errors;

        function new();
            frame_w = 256;
            frame_h = 256;
            tile_w  = 8;
            tile_h  = 8;
            errors  = 0;
            foreach (dirty[i])
            begin
                dirty[i] = 1'b1;
            end
        endfunction

        // zero acts as one, anything past the limit acts as the limit
        function int limit_size(input logic [CFG_W-1:0] v, input int hi);
            if (v == '0)
            begin
                return 1;
            end
            if (int'(v) > hi)
            begin
                return hi;
            end
            return int'(v);
        endfunction

        function void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] v);
            case (idx)
                REG_FRAME_WIDTH:  frame_w = limit_size(v, MAX_WIDTH_DEF);
                REG_FRAME_HEIGHT: frame_h = limit_size(v, MAX_HEIGHT_DEF);
                REG_TILE_WIDTH:   tile_w  = limit_size(v, TILE_MAX);
                REG_TILE_HEIGHT:  tile_h  = limit_size(v, TILE_MAX);
                default: ;
            endcase
        endfunction

        function int tile_cols();
            return (frame_w + tile_w - 1) / tile_w;
        endfunction

        function int tile_count();
            return tile_cols() * ((frame_h + tile_h - 1) / tile_h);
        endfunction

        // applies one accepted request to the store and queues its response
        function void note_request(input pixel_req_t r);
            pixel_rsp_t e;
            int         px;
            int         py;
            int         addr;
            int         t;
            e  = '{read_value: '0, tile_dirty: 1'b0, status: ST_OK};
            px = int'(r.x);
            py = int'(r.y);
            if (r.kind == REQ_WRITE || r.kind == REQ_READ)
            begin
                if (px >= frame_w || py >= frame_h)
                begin
                    e.status = ST_RANGE;
                end
                else
                begin
                    addr = px + py * frame_w;
                    if (r.kind == REQ_WRITE)
                    begin
                        pixels[addr] = r.color;
                        if (!pixel_written[addr])
                        begin
                            pixel_written[addr] = 1'b1;
                            written_addrs.push_back(addr);
                        end
                        t = px / tile_w + (py / tile_h) * tile_cols();
                        dirty[t] = 1'b1;
                    end
                    else
                    begin
                        e.read_value = pixels[addr];
                    end
                end
            end
            else
            begin
                t = int'(r.tile);
                if (t >= tile_count())
                begin
                    e.status = ST_RANGE;
                end
                else if (r.kind == REQ_QUERY)
                begin
                    e.tile_dirty = dirty[t];
                end
                else
                begin
                    dirty[t] = 1'b0;
                end
            end
            expected_q.push_back(e);
        endfunction

        function void check_result(input pixel_rsp_t got);
            pixel_rsp_t e;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected response, expected none, actual %h/%b/%b", $time,
                         got.read_value, got.tile_dirty, got.status);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (got.read_value !== e.read_value)
            begin
                $display("%0t: read_value mismatch, expected %h actual %h", $time,
                         e.read_value, got.read_value);
                errors++;
            end
            if (got.tile_dirty !== e.tile_dirty)
            begin
                $display("%0t: tile_dirty mismatch, expected %b actual %b", $time,
                         e.tile_dirty, got.tile_dirty);
                errors++;
            end
            if (got.status !== e.status)
            begin
                $display("%0t: status mismatch, expected %b actual %b", $time,
                         e.status, got.status);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    tfdt_req_if req_if();
    tfdt_rsp_if rsp_if();
    tfdt_cfg_if cfg_if();

    tiled_framebuffer_dirty_tracker dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if),
        .cfg   (cfg_if)
    );

    framebuffer_scoreboard sb = new();

    int send_idle_pct    = 0;
    int rsp_stall_pct    = 0;
    bit rsp_hold_request = 1'b0;
    int cycle_count      = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("tb_top failed");
            $finish;
        end
    end

    // response side: random stalls plus an occasional long hold-off
    initial
    begin : rsp_driver
        int hold_left;
        hold_left = 0;
        rsp_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (rsp_hold_request)
            begin
                rsp_hold_request = 1'b0;
                hold_left = RSP_HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end
            else
            begin
                rsp_if.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
        begin
            sb.check_result('{rsp_if.read_value, rsp_if.tile_dirty, rsp_if.status});
        end
    end

    function automatic pixel_req_t make_item(input logic [REQ_W-1:0] kind, input int x,
                                             input int y, input int color, input int tile);
        pixel_req_t r;
        r.kind  = kind;
        r.x     = POS_W'(x);
        r.y     = POS_W'(y);
        r.color = PIX_W'(color);
        r.tile  = TIDX_W'(tile);
        return r;
    endfunction

    // called at a falling edge, returns at the falling edge after the transaction
    task automatic send_request(input pixel_req_t r);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_if.valid <= 1'b0;
            @(negedge clk);
        end
        req_if.valid       <= 1'b1;
        req_if.req_type    <= r.kind;
        req_if.pos_x       <= r.x;
        req_if.pos_y       <= r.y;
        req_if.pixel_value <= r.color;
        req_if.tile_index  <= r.tile;
        @(posedge clk);
        while (req_if.ready !== 1'b1)
        begin
            @(posedge clk);
        end
        sb.note_request(r);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        req_if.valid <= 1'b0;
        @(negedge clk);
        while (sb.expected_q.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic reconfigure(input logic [CFG_W-1:0] fw, input logic [CFG_W-1:0] fh,
                               input logic [CFG_W-1:0] tw, input logic [CFG_W-1:0] th);
        logic [CFG_W-1:0]     vals [4];
        logic [CFG_IDX_W-1:0] idx [4];
        vals = '{fw, fh, tw, th};
        idx  = '{REG_FRAME_WIDTH, REG_FRAME_HEIGHT, REG_TILE_WIDTH, REG_TILE_HEIGHT};
        wait_drained();
        for (int i = 0; i < 4; i++)
        begin
            cfg_if.valid <= 1'b1;
            cfg_if.index <= idx[i];
            cfg_if.data  <= vals[i];
            @(posedge clk);
            while (cfg_if.ready !== 1'b1)
            begin
                @(posedge clk);
            end
            sb.set_reg(idx[i], vals[i]);
            @(negedge clk);
        end
        cfg_if.valid <= 1'b0;
    endtask

    task automatic run_random(input int count, input int idle_pct, input int stall_pct,
                              input bit hold, input bit pause);
        pixel_req_t r;
        int         roll;
        int         cnt;
        int         pick;
        bit         found;
        send_idle_pct = idle_pct;
        rsp_stall_pct = stall_pct;
        if (hold)
        begin
            rsp_hold_request = 1'b1;
        end
        for (int n = 0; n < count; n++)
        begin
            if (pause && n == count / 2)
            begin
                wait_drained();
            end
            // don't-care fields stay random too
            r = make_item($urandom_range(0, 3), $urandom_range(0, 255), $urandom_range(0, 255),
                          $urandom, $urandom_range(0, 65535));
            roll = $urandom_range(0, 99);
            if (roll < 40)
            begin
                r.kind = REQ_WRITE;
                if ($urandom_range(0, 99) < 85)
                begin
                    r.x = POS_W'($urandom_range(0, sb.frame_w - 1));
                    r.y = POS_W'($urandom_range(0, sb.frame_h - 1));
                end
            end
            else if (roll < 65)
            begin
                r.kind = REQ_READ;
                found = 1'b0;
                if ($urandom_range(0, 99) < 15 && (sb.frame_w < 256 || sb.frame_h < 256))
                begin
                    if (sb.frame_w < 256 && (sb.frame_h == 256 || $urandom_range(0, 1) == 0))
                    begin
                        r.x = POS_W'($urandom_range(sb.frame_w, 255));
                    end
                    else
                    begin
                        r.y = POS_W'($urandom_range(sb.frame_h, 255));
                    end
                    found = 1'b1;
                end
                for (int t = 0; t < 8 && !found && sb.written_addrs.size() != 0; t++)
                begin
                    pick = sb.written_addrs[$urandom_range(0, sb.written_addrs.size() - 1)];
                    if (pick / sb.frame_w < sb.frame_h)
                    begin
                        r.x = POS_W'(pick % sb.frame_w);
                        r.y = POS_W'(pick / sb.frame_w);
                        found = 1'b1;
                    end
                end
                // nothing readable under this mapping, write instead
                if (!found)
                begin
                    r.kind = REQ_WRITE;
                    r.x = POS_W'($urandom_range(0, sb.frame_w - 1));
                    r.y = POS_W'($urandom_range(0, sb.frame_h - 1));
                end
            end
            else if (roll < 95)
            begin
                r.kind = ($urandom_range(0, 1) == 0) ? REQ_QUERY : REQ_CLEAR;
                cnt = sb.tile_count();
                roll = $urandom_range(0, 99);
                if (roll < 70)
                begin
                    r.tile = TIDX_W'($urandom_range(0, cnt - 1));
                end
                else if (roll < 85 && cnt < STORE_DEPTH)
                begin
                    r.tile = TIDX_W'($urandom_range(cnt, STORE_DEPTH - 1));
                end
            end
            else if (r.kind == REQ_READ && int'(r.x) < sb.frame_w && int'(r.y) < sb.frame_h)
            begin
                if (!sb.pixel_written[int'(r.x) + int'(r.y) * sb.frame_w])
                begin
                    r.kind = REQ_WRITE;
                end
            end
            send_request(r);
        end
    endtask

    initial
    begin
        rst_n              = 1'b0;
        req_if.valid       = 1'b0;
        req_if.req_type    = REQ_WRITE;
        req_if.pos_x       = '0;
        req_if.pos_y       = '0;
        req_if.pixel_value = '0;
        req_if.tile_index  = '0;
        cfg_if.valid       = 1'b0;
        cfg_if.index       = REG_FRAME_WIDTH;
        cfg_if.data        = '0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset geometry: 256x256 frame, 8x8 tiles, 1024 tiles
        send_request(make_item(REQ_QUERY, 0, 0, 0, 0));
        send_request(make_item(REQ_CLEAR, 0, 0, 0, 0));
        send_request(make_item(REQ_QUERY, 0, 0, 0, 0));
        send_request(make_item(REQ_WRITE, 0, 0, 'h000000, 0));
        send_request(make_item(REQ_QUERY, 0, 0, 0, 0));
        send_request(make_item(REQ_WRITE, 255, 255, 'hFFFFFF, 0));
        send_request(make_item(REQ_READ, 255, 255, 0, 0));
        send_request(make_item(REQ_READ, 0, 0, 0, 0));
        send_request(make_item(REQ_CLEAR, 0, 0, 0, 1023));
        send_request(make_item(REQ_QUERY, 0, 0, 0, 1023));
        send_request(make_item(REQ_QUERY, 0, 0, 0, 1024));
        send_request(make_item(REQ_CLEAR, 0, 0, 0, 65535));
        send_request(make_item(REQ_WRITE, 'hAA, 'h55, 'hA5A5A5, 0));
        send_request(make_item(REQ_READ, 'hAA, 'h55, 0, 0));
        send_request(make_item(REQ_WRITE, 'h55, 'hAA, 'h5A5A5A, 0));
        send_request(make_item(REQ_READ, 'h55, 'hAA, 0, 0));
        run_random(150, 0, 0, 1'b0, 1'b0);

        // 100x50 frame, 7x3 tiles: 15 columns by 17 rows
        reconfigure(100, 50, 7, 3);
        send_request(make_item(REQ_WRITE, 100, 0, 'h123456, 0));
        send_request(make_item(REQ_WRITE, 0, 50, 'h654321, 0));
        send_request(make_item(REQ_READ, 255, 255, 0, 0));
        send_request(make_item(REQ_WRITE, 99, 49, 'h0F0F0F, 0));
        send_request(make_item(REQ_READ, 99, 49, 0, 0));
        send_request(make_item(REQ_QUERY, 0, 0, 0, 254));
        send_request(make_item(REQ_QUERY, 0, 0, 0, 255));
        run_random(200, 72, 0, 1'b0, 1'b0);

        // zero sizes act as one
        reconfigure(0, 0, 0, 0);
        run_random(60, 0, 72, 1'b0, 1'b0);

        // oversized values clamp: full frame with one tile per pixel
        reconfigure(511, 511, 1, 1);
        run_random(200, 17, 17, 1'b0, 1'b0);

        // single tile covering the frame, response side held off at the start
        reconfigure(256, 300, 511, 300);
        run_random(150, 0, 0, 1'b1, 1'b0);

        reconfigure(170, 85, 13, 9);
        run_random(200, 0, 72, 1'b0, 1'b0);

        reconfigure(37, 200, 256, 5);
        run_random(150, 17, 17, 1'b0, 1'b1);

        reconfigure(256, 256, 8, 8);
        run_random(200, 72, 0, 1'b0, 1'b0);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.expected_q.size() != 0)
        begin
            $display("%0t: %0d responses never arrived", $time, sb.expected_q.size());
        end
        if (sb.errors == 0 && sb.expected_q.size() == 0)
        begin
            $display("tb_top passed");
        end
        else
        begin
            $display("tb_top failed");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
design/tfdt_pkg.sv
design/tfdt_ifs.sv
design/tfdt_divider.sv
design/tfdt_datapath.sv
design/tfdt_ctrl.sv
design/tiled_framebuffer_dirty_tracker.sv
verif/tb_top.sv
